### rtl/core/packed_nibble_framebuffer_draw_unit_assert.svh
// assertion macros used by the draw unit back end
`ifndef PACKED_NIBBLE_FRAMEBUFFER_DRAW_UNIT_ASSERT_SVH
`define PACKED_NIBBLE_FRAMEBUFFER_DRAW_UNIT_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define PNFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence must hold in the cycle after the antecedent
`define PNFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pnfd_pkg.sv
// shared constants, codes and types of the 4bpp framebuffer draw unit
package pnfd_pkg;

  // geometry of the store
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 64;
  localparam int PAIRS_MAX   = MAX_WIDTH / 2;
  localparam int STORE_BYTES = PAIRS_MAX * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int X_W         = $clog2(MAX_WIDTH);
  localparam int Y_W         = $clog2(MAX_HEIGHT);

  // field and register widths
  localparam int POS_W    = 11;
  localparam int SIZE_W   = 10;
  localparam int COLOR_W  = 4;
  localparam int ACTION_W = 3;
  localparam int PAIRS_W  = 8;
  localparam int HEIGHT_W = 7;
  localparam int C_W      = POS_W + 1;

  // command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // nibble masks
  localparam logic [7:0] NIB_LO_MASK = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK = 8'hF0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT     = 3'd0,
    ACT_GET     = 3'd1,
    ACT_FILL    = 3'd2,
    ACT_RECT    = 3'd3,
    ACT_OUTLINE = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_GET,
    CMD_FILL,
    CMD_RECT,
    CMD_OUTLINE
  } cmd_e;

  typedef enum logic [0:0] {
    REG_WIDTH_PAIRS   = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_e;

  // which pixel of the current command the back end is visiting
  typedef enum logic [2:0] {
    PH_SINGLE,
    PH_RECT,
    PH_TOP,
    PH_BOT,
    PH_LEFT,
    PH_RIGHT
  } ph_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PIX_RD,
    BK_PIX_WR,
    BK_FILL,
    BK_DONE
  } bk_state_e;

  typedef logic signed [C_W-1:0] coord_t;

  // saturated screen geometry
  typedef struct packed {
    logic [PAIRS_W-1:0]  pairs;
    logic [PAIRS_W:0]    scr_w;
    logic [HEIGHT_W-1:0] scr_h;
  } geom_t;

  // classified command as held in the queue
  typedef struct packed {
    cmd_e               kind;
    coord_t             x;
    coord_t             y;
    coord_t             x2;
    coord_t             y2;
    coord_t             i_lo;
    coord_t             i_hi;
    coord_t             j_lo;
    coord_t             j_hi;
    logic               row_ok;
    logic               col_ok;
    logic [COLOR_W-1:0] color;
    logic [CNT_W-1:0]   fill_n;
  } cmd_t;

endpackage

### rtl/core/pnfd_front.sv
// front end: accepts items and turns them into clipped commands
module pnfd_front (
  input  logic                                 in_valid_i,
  input  logic [pnfd_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [pnfd_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [pnfd_pkg::POS_W-1:0]    pos_y_i,
  input  logic [pnfd_pkg::SIZE_W-1:0]          rect_width_i,
  input  logic [pnfd_pkg::SIZE_W-1:0]          rect_height_i,
  input  logic [pnfd_pkg::COLOR_W-1:0]         color_i,
  input  pnfd_pkg::geom_t                      geom_i,
  input  logic                                 clearing_i,
  input  logic                                 q_full_i,
  output logic                                 in_stall_o,
  output logic                                 push_o,
  output pnfd_pkg::cmd_t                       push_data_o
);

  pnfd_pkg::coord_t x_s, y_s, rw_c, rh_c, x_end, y_end, w_c, h_c;
  pnfd_pkg::coord_t i_lo, i_hi, j_lo, j_hi;
  logic             row_ok, col_ok;
  logic [pnfd_pkg::CNT_W-1:0] fill_n;

  // accept whenever the queue has room and the store is not being cleared
  assign in_stall_o = q_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // rectangle edges and their clipped spans
  always_comb begin
    x_s   = pnfd_pkg::C_W'(pos_x_i);
    y_s   = pnfd_pkg::C_W'(pos_y_i);
    rw_c  = pnfd_pkg::coord_t'(rect_width_i);
    rh_c  = pnfd_pkg::coord_t'(rect_height_i);
    x_end = x_s + rw_c;
    y_end = y_s + rh_c;
    w_c   = pnfd_pkg::coord_t'(geom_i.scr_w);
    h_c   = pnfd_pkg::coord_t'(geom_i.scr_h);
    i_lo  = x_s[pnfd_pkg::C_W-1] ? '0 : x_s;
    j_lo  = y_s[pnfd_pkg::C_W-1] ? '0 : y_s;
    i_hi  = (x_end > w_c) ? w_c : x_end;
    j_hi  = (y_end > h_c) ? h_c : y_end;
    row_ok = i_lo < i_hi;
    col_ok = j_lo < j_hi;
    fill_n = pnfd_pkg::CNT_W'(geom_i.pairs) * pnfd_pkg::CNT_W'(geom_i.scr_h);
  end

  // classification, empty work becomes a no-op that still returns a result
  always_comb begin
    push_data_o.x      = x_s;
    push_data_o.y      = y_s;
    push_data_o.x2     = x_end - pnfd_pkg::coord_t'(1);
    push_data_o.y2     = y_end - pnfd_pkg::coord_t'(1);
    push_data_o.i_lo   = i_lo;
    push_data_o.i_hi   = i_hi;
    push_data_o.j_lo   = j_lo;
    push_data_o.j_hi   = j_hi;
    push_data_o.row_ok = row_ok;
    push_data_o.col_ok = col_ok;
    push_data_o.color  = color_i;
    push_data_o.fill_n = fill_n;
    case (pnfd_pkg::act_e'(action_i))
      pnfd_pkg::ACT_PUT: begin
        push_data_o.kind = pnfd_pkg::CMD_PUT;
      end
      pnfd_pkg::ACT_GET: begin
        push_data_o.kind = pnfd_pkg::CMD_GET;
      end
      pnfd_pkg::ACT_FILL: begin
        push_data_o.kind = (fill_n != '0) ? pnfd_pkg::CMD_FILL : pnfd_pkg::CMD_NOP;
      end
      pnfd_pkg::ACT_RECT: begin
        push_data_o.kind = (row_ok && col_ok) ? pnfd_pkg::CMD_RECT : pnfd_pkg::CMD_NOP;
      end
      pnfd_pkg::ACT_OUTLINE: begin
        push_data_o.kind = (row_ok || col_ok) ? pnfd_pkg::CMD_OUTLINE : pnfd_pkg::CMD_NOP;
      end
      default: begin
        push_data_o.kind = pnfd_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

### rtl/core/pnfd_queue.sv
// short command queue between front and back end
module pnfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pnfd_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pnfd_pkg::cmd_t data_o
);

  pnfd_pkg::cmd_t               entry_q [pnfd_pkg::Q_DEPTH];
  logic [pnfd_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [pnfd_pkg::Q_PTR_W:0]   count_q;
  logic                         do_push, do_pop;

  assign full_o  = count_q == (pnfd_pkg::Q_PTR_W + 1)'(pnfd_pkg::Q_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/core/pnfd_back.sv
// back end: pixel store, read-modify-write sequencer and result register
`include "packed_nibble_framebuffer_draw_unit_assert.svh"

module pnfd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pnfd_pkg::geom_t               geom_i,
  input  logic                          q_valid_i,
  input  pnfd_pkg::cmd_t                q_data_i,
  output logic                          q_pop_o,
  output logic                          clearing_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pnfd_pkg::COLOR_W-1:0]  pixel_value_o
);

  pnfd_pkg::bk_state_e state_q, state_d, launch_state;
  pnfd_pkg::cmd_t      cmd_q;
  pnfd_pkg::ph_e       ph_q, ph_d, ph_n;
  pnfd_pkg::coord_t    it_x_q, it_x_d, it_x_n, it_y_q, it_y_d, it_y_n;
  pnfd_pkg::coord_t    px, py, w_c, h_c;
  logic [pnfd_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [pnfd_pkg::ADDR_W-1:0]  addr_q, pix_addr, mem_waddr;
  logic [7:0]                   mem_q [pnfd_pkg::STORE_BYTES];
  logic [7:0]                   rdata_q, mem_wdata;
  logic                         mem_we;
  logic                         ok_q, odd_q, pix_ok;
  logic [pnfd_pkg::COLOR_W-1:0] res_q, out_pix_q, rd_nibble;
  logic                         out_valid_q, out_free, out_load, start;
  logic                         step_done, x_more, y_more;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_load      = (state_q == pnfd_pkg::BK_DONE) && out_free;
  assign start         = q_valid_i && ((state_q == pnfd_pkg::BK_IDLE) || out_load);
  assign q_pop_o       = start;
  assign clearing_o    = state_q == pnfd_pkg::BK_CLEAR;
  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_pix_q;
  assign rd_nibble     = odd_q ? rdata_q[3:0] : rdata_q[7:4];

  // pixel being visited, its clip check and byte address
  always_comb begin
    case (ph_q)
      pnfd_pkg::PH_RECT: begin
        px = it_x_q;
        py = it_y_q;
      end
      pnfd_pkg::PH_TOP: begin
        px = it_x_q;
        py = cmd_q.y;
      end
      pnfd_pkg::PH_BOT: begin
        px = it_x_q;
        py = cmd_q.y2;
      end
      pnfd_pkg::PH_LEFT: begin
        px = cmd_q.x;
        py = it_y_q;
      end
      pnfd_pkg::PH_RIGHT: begin
        px = cmd_q.x2;
        py = it_y_q;
      end
      default: begin
        px = cmd_q.x;
        py = cmd_q.y;
      end
    endcase
    w_c    = pnfd_pkg::coord_t'(geom_i.scr_w);
    h_c    = pnfd_pkg::coord_t'(geom_i.scr_h);
    pix_ok = !px[pnfd_pkg::C_W-1] && (px < w_c) && !py[pnfd_pkg::C_W-1] && (py < h_c);
    pix_addr = pnfd_pkg::ADDR_W'(
                 pnfd_pkg::ADDR_W'(py[pnfd_pkg::Y_W-1:0]) * pnfd_pkg::ADDR_W'(geom_i.pairs)
               + pnfd_pkg::ADDR_W'(px[pnfd_pkg::X_W-1:1]));
  end

  // walk to the next pixel of a rectangle or outline
  always_comb begin
    x_more    = (it_x_q + pnfd_pkg::coord_t'(1)) < cmd_q.i_hi;
    y_more    = (it_y_q + pnfd_pkg::coord_t'(1)) < cmd_q.j_hi;
    step_done = 1'b0;
    ph_n      = ph_q;
    it_x_n    = it_x_q;
    it_y_n    = it_y_q;
    case (ph_q)
      pnfd_pkg::PH_RECT: begin
        if (x_more) begin
          it_x_n = it_x_q + pnfd_pkg::coord_t'(1);
        end else if (y_more) begin
          it_x_n = cmd_q.i_lo;
          it_y_n = it_y_q + pnfd_pkg::coord_t'(1);
        end else begin
          step_done = 1'b1;
        end
      end
      pnfd_pkg::PH_TOP: begin
        ph_n = pnfd_pkg::PH_BOT;
      end
      pnfd_pkg::PH_BOT: begin
        if (x_more) begin
          it_x_n = it_x_q + pnfd_pkg::coord_t'(1);
          ph_n   = pnfd_pkg::PH_TOP;
        end else if (cmd_q.col_ok) begin
          it_y_n = cmd_q.j_lo;
          ph_n   = pnfd_pkg::PH_LEFT;
        end else begin
          step_done = 1'b1;
        end
      end
      pnfd_pkg::PH_LEFT: begin
        ph_n = pnfd_pkg::PH_RIGHT;
      end
      pnfd_pkg::PH_RIGHT: begin
        if (y_more) begin
          it_y_n = it_y_q + pnfd_pkg::coord_t'(1);
          ph_n   = pnfd_pkg::PH_LEFT;
        end else begin
          step_done = 1'b1;
        end
      end
      default: begin
        step_done = 1'b1;
      end
    endcase
  end

  // first state of a newly popped command
  always_comb begin
    case (q_data_i.kind)
      pnfd_pkg::CMD_PUT,
      pnfd_pkg::CMD_GET,
      pnfd_pkg::CMD_RECT,
      pnfd_pkg::CMD_OUTLINE: begin
        launch_state = pnfd_pkg::BK_PIX_RD;
      end
      pnfd_pkg::CMD_FILL: begin
        launch_state = pnfd_pkg::BK_FILL;
      end
      default: begin
        launch_state = pnfd_pkg::BK_DONE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pnfd_pkg::BK_CLEAR: begin
        if (cnt_q == pnfd_pkg::CNT_W'(pnfd_pkg::STORE_BYTES - 1)) begin
          state_d = pnfd_pkg::BK_IDLE;
        end
      end
      pnfd_pkg::BK_IDLE: begin
        if (start) begin
          state_d = launch_state;
        end
      end
      pnfd_pkg::BK_PIX_RD: begin
        state_d = pnfd_pkg::BK_PIX_WR;
      end
      pnfd_pkg::BK_PIX_WR: begin
        state_d = step_done ? pnfd_pkg::BK_DONE : pnfd_pkg::BK_PIX_RD;
      end
      pnfd_pkg::BK_FILL: begin
        if ((cnt_q + pnfd_pkg::CNT_W'(1)) == cmd_q.fill_n) begin
          state_d = pnfd_pkg::BK_DONE;
        end
      end
      pnfd_pkg::BK_DONE: begin
        if (out_load) begin
          state_d = start ? launch_state : pnfd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = pnfd_pkg::BK_IDLE;
      end
    endcase
  end

  // store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    case (state_q)
      pnfd_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[pnfd_pkg::ADDR_W-1:0];
      end
      pnfd_pkg::BK_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[pnfd_pkg::ADDR_W-1:0];
        mem_wdata = {cmd_q.color, cmd_q.color};
      end
      pnfd_pkg::BK_PIX_WR: begin
        mem_we = ok_q && (cmd_q.kind != pnfd_pkg::CMD_GET);
        if (odd_q) begin
          mem_wdata = (rdata_q & pnfd_pkg::NIB_HI_MASK) | {4'h0, cmd_q.color};
        end else begin
          mem_wdata = (rdata_q & pnfd_pkg::NIB_LO_MASK) | {cmd_q.color, 4'h0};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // iterator and counter next values
  always_comb begin
    ph_d   = ph_q;
    it_x_d = it_x_q;
    it_y_d = it_y_q;
    cnt_d  = cnt_q;
    if (start) begin
      it_x_d = q_data_i.i_lo;
      it_y_d = q_data_i.j_lo;
      cnt_d  = '0;
      case (q_data_i.kind)
        pnfd_pkg::CMD_RECT: begin
          ph_d = pnfd_pkg::PH_RECT;
        end
        pnfd_pkg::CMD_OUTLINE: begin
          ph_d = q_data_i.row_ok ? pnfd_pkg::PH_TOP : pnfd_pkg::PH_LEFT;
        end
        default: begin
          ph_d = pnfd_pkg::PH_SINGLE;
        end
      endcase
    end else begin
      case (state_q)
        pnfd_pkg::BK_CLEAR,
        pnfd_pkg::BK_FILL: begin
          cnt_d = cnt_q + pnfd_pkg::CNT_W'(1);
        end
        pnfd_pkg::BK_PIX_WR: begin
          ph_d   = ph_n;
          it_x_d = it_x_n;
          it_y_d = it_y_n;
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pnfd_pkg::BK_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command, iterator and result payload
  always_ff @(posedge clk_i) begin
    ph_q   <= ph_d;
    it_x_q <= it_x_d;
    it_y_q <= it_y_d;
    if (start) begin
      cmd_q <= q_data_i;
      res_q <= '0;
    end else if ((state_q == pnfd_pkg::BK_PIX_WR) && ok_q &&
                 (cmd_q.kind == pnfd_pkg::CMD_GET)) begin
      res_q <= rd_nibble;
    end
    if (state_q == pnfd_pkg::BK_PIX_RD) begin
      ok_q   <= pix_ok;
      odd_q  <= px[0];
      addr_q <= pix_addr;
    end
    if (out_load) begin
      out_pix_q <= res_q;
    end
  end

  // pixel store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[pix_addr];
  end

  `PNFD_ASSERT_NEXT(a_rd_then_wr, state_q == pnfd_pkg::BK_PIX_RD, state_q == pnfd_pkg::BK_PIX_WR, "pixel read not followed by its write")
  `PNFD_ASSERT_NOW(a_pop_when_free, q_pop_o, (state_q == pnfd_pkg::BK_IDLE) || (state_q == pnfd_pkg::BK_DONE), "command popped while busy")
  `PNFD_ASSERT_NOW(a_no_result_in_clear, state_q == pnfd_pkg::BK_CLEAR, !out_valid_q, "result shown during clearing pass")
  `PNFD_ASSERT_NOW(a_fill_in_range, state_q == pnfd_pkg::BK_FILL, cnt_q < cmd_q.fill_n, "fill ran past screen size")

endmodule

### rtl/core/packed_nibble_framebuffer_draw_unit.sv
// 4bpp framebuffer draw unit: config registers and front/queue/back wiring
//
// Input channel (in_valid_i / in_stall_o) carries one drawing item: write
// pixel, read pixel, fill screen, fill rectangle or rectangle outline. Every
// item gives exactly one result on the output channel (out_valid_o /
// out_stall_i): the pixel read, or zero for every other action.
// width_in_pairs and screen_height are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i while the unit is idle; they take effect on the next item.
// Items are classified and clipped on entry and wait in a two-entry queue;
// the back end performs a read-modify-write per pixel on the byte store,
// one registered read and one write a cycle. Pixel write or read: a read
// state, a write state, then the done state that loads the result register.
// Fill screen: writes width_in_pairs * screen_height bytes, both saturated
// to the store size. Filled rectangle: a read and a write per clipped pixel.
// Outline: a read and a write for the top and bottom pixel of each clipped
// column and the left and right pixel of each clipped row. Empty work goes
// straight to the done state. After reset all 8192 bytes are swept to zero,
// one byte a cycle; in_stall_o stays high meanwhile. A stalled result holds
// in the output register; the queue keeps taking items until it is full.
module packed_nibble_framebuffer_draw_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_idx_i,
  input  logic [pnfd_pkg::PAIRS_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pnfd_pkg::ACTION_W-1:0]       action_i,
  input  logic signed [pnfd_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [pnfd_pkg::POS_W-1:0]   pos_y_i,
  input  logic [pnfd_pkg::SIZE_W-1:0]         rect_width_i,
  input  logic [pnfd_pkg::SIZE_W-1:0]         rect_height_i,
  input  logic [pnfd_pkg::COLOR_W-1:0]        color_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pnfd_pkg::COLOR_W-1:0]        pixel_value_o
);

  logic [pnfd_pkg::PAIRS_W-1:0]  width_pairs_q;
  logic [pnfd_pkg::HEIGHT_W-1:0] screen_height_q;
  pnfd_pkg::geom_t               geom;
  pnfd_pkg::cmd_t                push_data, q_data;
  logic                          push, q_full, q_valid, q_pop, clearing;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_pairs_q   <= pnfd_pkg::PAIRS_W'(128);
      screen_height_q <= pnfd_pkg::HEIGHT_W'(48);
    end else if (cfg_we_i) begin
      case (pnfd_pkg::reg_e'(cfg_idx_i))
        pnfd_pkg::REG_WIDTH_PAIRS: begin
          width_pairs_q <= cfg_wdata_i;
        end
        pnfd_pkg::REG_SCREEN_HEIGHT: begin
          screen_height_q <= cfg_wdata_i[pnfd_pkg::HEIGHT_W-1:0];
        end
        default: begin
          width_pairs_q <= width_pairs_q;
        end
      endcase
    end
  end

  // saturate the geometry to the store size
  always_comb begin
    geom.pairs = (width_pairs_q > pnfd_pkg::PAIRS_W'(pnfd_pkg::PAIRS_MAX))
               ? pnfd_pkg::PAIRS_W'(pnfd_pkg::PAIRS_MAX) : width_pairs_q;
    geom.scr_w = {geom.pairs, 1'b0};
    geom.scr_h = (screen_height_q > pnfd_pkg::HEIGHT_W'(pnfd_pkg::MAX_HEIGHT))
               ? pnfd_pkg::HEIGHT_W'(pnfd_pkg::MAX_HEIGHT) : screen_height_q;
  end

  pnfd_front u_front (
    .in_valid_i    (in_valid_i),
    .action_i      (action_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .color_i       (color_i),
    .geom_i        (geom),
    .clearing_i    (clearing),
    .q_full_i      (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  pnfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  pnfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geom_i        (geom),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o)
  );

endmodule

### tb/tb_packed_nibble_framebuffer_draw_unit.sv
// testbench for the 4bpp framebuffer draw unit: directed table, then random items under varying geometry
`timescale 1ns / 100ps

module tb_packed_nibble_framebuffer_draw_unit;
  import pnfd_pkg::*;

  // actions the unit does not know
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int DIR_N           = 25;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int CYCLE_LIMIT     = 3_000_000;

  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
    logic [COLOR_W-1:0]      color;
  } draw_cmd_t;

  // one directed row: item plus an optional hand-written answer
  typedef struct packed {
    draw_cmd_t          cmd;
    logic               pinned;
    logic [COLOR_W-1:0] pinned_val;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [0:0]              cfg_idx_i;
  logic [PAIRS_W-1:0]      cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ACTION_W-1:0]     action_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_y_i;
  logic [SIZE_W-1:0]       rect_width_i;
  logic [SIZE_W-1:0]       rect_height_i;
  logic [COLOR_W-1:0]      color_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [COLOR_W-1:0]      pixel_value_o;

  packed_nibble_framebuffer_draw_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .color_i       (color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o)
  );

  // shadow framebuffer and geometry registers
  logic [7:0]          shadow_fb [STORE_BYTES];
  logic [PAIRS_W-1:0]  fb_pairs  = 8'd128;
  logic [HEIGHT_W-1:0] fb_height = 7'd48;

  logic [COLOR_W-1:0] pixel_expect_q [$];
  int                 mismatch_count = 0;
  int                 burst_left     = 0;
  bit                 hold_off_req   = 1'b0;
  dir_row_t           dir_rows [DIR_N];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // effective screen size after saturation
  function automatic int scr_w();
    return 2 * ((int'(fb_pairs) > PAIRS_MAX) ? PAIRS_MAX : int'(fb_pairs));
  endfunction

  function automatic int scr_h();
    return (int'(fb_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(fb_height);
  endfunction

  // clipped nibble write
  function automatic void plot_px(int x, int y, logic [COLOR_W-1:0] c);
    int wd;
    int idx;
    wd = scr_w();
    if (x < 0 || x >= wd || y < 0 || y >= scr_h()) return;
    idx = y * (wd / 2) + x / 2;
    if (idx >= STORE_BYTES) return;
    if (x % 2 == 0) shadow_fb[idx] = (shadow_fb[idx] & NIB_LO_MASK) | {c, 4'h0};
    else shadow_fb[idx] = (shadow_fb[idx] & NIB_HI_MASK) | {4'h0, c};
  endfunction

  // nibble read, zero off screen
  function automatic logic [COLOR_W-1:0] px_at(int x, int y);
    int wd;
    int idx;
    wd = scr_w();
    if (x < 0 || x >= wd || y < 0 || y >= scr_h()) return '0;
    idx = y * (wd / 2) + x / 2;
    if (idx >= STORE_BYTES) return '0;
    return (x % 2 == 0) ? shadow_fb[idx][7:4] : shadow_fb[idx][3:0];
  endfunction

  // applies one item to the shadow store and returns the pixel the unit should answer
  function automatic logic [COLOR_W-1:0] draw_predict(draw_cmd_t cmd);
    int x, y, w, h, wd, ht, i, j, n, a, b;
    logic [COLOR_W-1:0] val;
    x   = int'(cmd.x);
    y   = int'(cmd.y);
    w   = int'(cmd.w);
    h   = int'(cmd.h);
    wd  = scr_w();
    ht  = scr_h();
    val = '0;
    case (cmd.action)
      ACT_PUT: plot_px(x, y, cmd.color);
      ACT_GET: val = px_at(x, y);
      ACT_FILL: begin
        n = (wd / 2) * ht;
        if (n > STORE_BYTES) n = STORE_BYTES;
        for (i = 0; i < n; i++) shadow_fb[i] = {cmd.color, cmd.color};
      end
      ACT_RECT: begin
        a = (x < 0) ? 0 : x;
        b = (x + w > wd) ? wd : x + w;
        for (j = (y < 0) ? 0 : y; j < ((y + h > ht) ? ht : y + h); j++)
          for (i = a; i < b; i++) plot_px(i, j, cmd.color);
      end
      ACT_OUTLINE: begin
        // rows first, then columns, degenerate sizes as they fall
        for (i = (x < 0) ? 0 : x; i < ((x + w > wd) ? wd : x + w); i++) begin
          plot_px(i, y, cmd.color);
          plot_px(i, y + h - 1, cmd.color);
        end
        for (j = (y < 0) ? 0 : y; j < ((y + h > ht) ? ht : y + h); j++) begin
          plot_px(x, j, cmd.color);
          plot_px(x + w - 1, j, cmd.color);
        end
      end
      default: ;
    endcase
    return val;
  endfunction

  // random item, mostly near the screen with small sizes
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int        r;
    r = $urandom_range(0, 99);
    if (r < 30) c.action = ACT_PUT;
    else if (r < 60) c.action = ACT_GET;
    else if (r < 75) c.action = ACT_RECT;
    else if (r < 90) c.action = ACT_OUTLINE;
    else if (r < 93) c.action = ACT_FILL;
    else c.action = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if ($urandom_range(0, 9) == 0) c.x = POS_W'($urandom);
    else c.x = POS_W'(int'($urandom_range(0, scr_w() + 15)) - 8);
    if ($urandom_range(0, 9) == 0) c.y = POS_W'($urandom);
    else c.y = POS_W'(int'($urandom_range(0, scr_h() + 15)) - 8);
    if ($urandom_range(0, 9) == 0) c.w = SIZE_W'($urandom);
    else c.w = SIZE_W'($urandom_range(0, 12));
    if ($urandom_range(0, 9) == 0) c.h = SIZE_W'($urandom);
    else c.h = SIZE_W'($urandom_range(0, 12));
    c.color = COLOR_W'($urandom);
    return c;
  endfunction

  // register write, unit idle
  task automatic write_reg(reg_e idx, logic [PAIRS_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_WIDTH_PAIRS) fb_pairs = val;
    else fb_height = val[HEIGHT_W-1:0];
  endtask

  // present one item and hold it until taken
  task automatic offer(draw_cmd_t cmd, logic pinned, logic [COLOR_W-1:0] pinned_val);
    logic [COLOR_W-1:0] predicted;
    in_valid_i    <= 1'b1;
    action_i      <= cmd.action;
    pos_x_i       <= cmd.x;
    pos_y_i       <= cmd.y;
    rect_width_i  <= cmd.w;
    rect_height_i <= cmd.h;
    color_i       <= cmd.color;
    do @(posedge clk_i); while (in_stall_o);
    predicted = draw_predict(cmd);
    pixel_expect_q.push_back(pinned ? pinned_val : predicted);
  endtask

  // bursts of items with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // wait for every answer, then let the unit go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // stimulus
  initial begin : stimulus
    int                 ph;
    int                 k;
    logic [PAIRS_W-1:0] pairs_val;
    logic [PAIRS_W-1:0] height_val;
    logic [PAIRS_W-1:0] phase_pairs  [N_PHASES];
    logic [PAIRS_W-1:0] phase_height [N_PHASES];

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_WIDTH_PAIRS;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    action_i      = ACT_PUT;
    pos_x_i       = '0;
    pos_y_i       = '0;
    rect_width_i  = '0;
    rect_height_i = '0;
    color_i       = '0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

    phase_pairs  = '{8'd128, 8'd1, 8'd3, 8'd0, 8'd255, 8'd64, 8'd17, 8'd0};
    phase_height = '{8'd64, 8'd1, 8'd5, 8'd20, 8'hFF, 8'd0, 8'd33, 8'd0};

    // directed rows under the reset geometry of 256 x 48
    dir_rows = '{
      '{'{ACT_GET,     11'sd0,    11'sd0,    10'd0,    10'd0,    4'h0}, 1'b1, 4'h0},
      '{'{ACT_GET,     11'sd255,  11'sd47,   10'd0,    10'd0,    4'h0}, 1'b1, 4'h0},
      '{'{ACT_PUT,     11'sd0,    11'sd0,    10'd0,    10'd0,    4'hF}, 1'b1, 4'h0},
      '{'{ACT_PUT,     11'sd1,    11'sd0,    10'd1023, 10'd1023, 4'hA}, 1'b1, 4'h0},
      '{'{ACT_GET,     11'sd0,    11'sd0,    10'd0,    10'd0,    4'h0}, 1'b1, 4'hF},
      '{'{ACT_GET,     11'sd1,    11'sd0,    10'd0,    10'd0,    4'h0}, 1'b0, 4'h0},
      '{'{ACT_PUT,     11'sh400,  11'sd5,    10'd0,    10'd0,    4'h7}, 1'b1, 4'h0},
      '{'{ACT_PUT,     11'sd1023, 11'sh400,  10'd0,    10'd0,    4'h7}, 1'b1, 4'h0},
      '{'{ACT_GET,     -11'sd1,   11'sd0,    10'd0,    10'd0,    4'h0}, 1'b1, 4'h0},
      '{'{ACT_GET,     11'sd256,  11'sd0,    10'd0,    10'd0,    4'h0}, 1'b1, 4'h0},
      '{'{ACT_GET,     11'sd0,    11'sd48,   10'd0,    10'd0,    4'h0}, 1'b1, 4'h0},
      '{'{ACT_PUT,     11'sd255,  11'sd47,   10'd0,    10'd0,    4'h9}, 1'b1, 4'h0},
      '{'{ACT_GET,     11'sd255,  11'sd47,   10'd0,    10'd0,    4'h0}, 1'b0, 4'h0},
      '{'{ACT_RECT,    11'sd250,  11'sd44,   10'd20,   10'd10,   4'h5}, 1'b1, 4'h0},
      '{'{ACT_GET,     11'sd252,  11'sd46,   10'd0,    10'd0,    4'h0}, 1'b0, 4'h0},
      '{'{ACT_RECT,    11'sd10,   11'sd10,   10'd0,    10'd5,    4'h3}, 1'b1, 4'h0},
      '{'{ACT_RECT,    11'sd10,   11'sd10,   10'd5,    10'd0,    4'h3}, 1'b1, 4'h0},
      '{'{ACT_OUTLINE, -11'sd3,   -11'sd2,   10'd8,    10'd6,    4'hC}, 1'b1, 4'h0},
      '{'{ACT_GET,     11'sd4,    11'sd3,    10'd0,    10'd0,    4'h0}, 1'b0, 4'h0},
      '{'{ACT_OUTLINE, 11'sd20,   11'sd20,   10'd1,    10'd1,    4'h6}, 1'b1, 4'h0},
      '{'{ACT_OUTLINE, 11'sd30,   11'sd0,    10'd1,    10'd1023, 4'h1}, 1'b1, 4'h0},
      '{'{ACT_GET,     11'sd20,   11'sd20,   10'd0,    10'd0,    4'h0}, 1'b0, 4'h0},
      '{'{ACT_SPARE_LO, 11'sd0,   11'sd0,    10'd3,    10'd3,    4'h4}, 1'b1, 4'h0},
      '{'{ACT_FILL,    11'sd0,    11'sd0,    10'd0,    10'd0,    4'h3}, 1'b1, 4'h0},
      '{'{ACT_RECT,    11'sd0,    11'sd0,    10'd1023, 10'd1023, 4'hA}, 1'b1, 4'h0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    for (k = 0; k < DIR_N; k++) begin
      offer(dir_rows[k].cmd, dir_rows[k].pinned, dir_rows[k].pinned_val);
      pace();
    end

    // random part, one geometry per phase
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      pairs_val  = (ph == N_PHASES - 1) ? PAIRS_W'($urandom_range(1, PAIRS_MAX))
                                        : phase_pairs[ph];
      height_val = (ph == N_PHASES - 1) ? PAIRS_W'($urandom_range(1, MAX_HEIGHT))
                                        : phase_height[ph];
      write_reg(REG_WIDTH_PAIRS, pairs_val);
      write_reg(REG_SCREEN_HEIGHT, height_val);
      // long receiver hold while items keep coming
      if (ph == 0) hold_off_req = 1'b1;
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        offer(random_cmd(), 1'b0, '0);
        pace();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("packed_nibble_framebuffer_draw_unit: match");
    end else begin
      $display("packed_nibble_framebuffer_draw_unit: mismatch");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold on request
  initial begin : sink_pattern
    int seg_len;
    int mode;
    int k;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(8, 60);
      for (k = 0; k < seg_len && !hold_off_req; k++) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= 1'($urandom_range(0, 1));
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (k % 4 == 3);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // compare each result against the oldest expected pixel
  always @(posedge clk_i) begin : result_check
    logic [COLOR_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_expect_q.size() == 0) begin
        $error("pixel_value: no item expected, got %0h", pixel_value_o);
        mismatch_count++;
      end else begin
        want = pixel_expect_q.pop_front();
        if (pixel_value_o !== want) begin
          $error("pixel_value: expected %0h, got %0h", want, pixel_value_o);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("packed_nibble_framebuffer_draw_unit: mismatch");
    $finish;
  end

endmodule
